[hdl/complex_fir_decimator_defines.svh]
// assertion helpers, clocked on clk_i and quiet during reset
`ifndef COMPLEX_FIR_DECIMATOR_DEFINES_SVH
`define COMPLEX_FIR_DECIMATOR_DEFINES_SVH

`define CFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define CFD_ASSERT_IMPL(name, ante, cons, msg) \
  `CFD_ASSERT(name, (ante) |-> (cons), msg)

`endif

[hdl/cfd_pkg.sv]
package cfd_pkg;

  localparam int MAX_TAPS  = 256;
  localparam int TAP_AW    = $clog2(MAX_TAPS);
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int ACC_W     = 40;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int CFG_W     = 9;
  localparam int CFG_IW    = 1;
  localparam int PHASE_W   = 8;
  localparam int MAX_DECIM = 256;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_COEF   = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_DECIM = 1'b0,
    CFG_TAPS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic [TAP_AW-1:0]          tap_index;
    logic signed [COEF_W-1:0]   tap_value;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic                       saturated;
  } res_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

[hdl/cfd_req_if.sv]
interface cfd_req_if import cfd_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/cfd_res_if.sv]
interface cfd_res_if import cfd_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/cfd_ram.sv]
module cfd_ram #(
  parameter int Depth = 256,
  parameter int Width = 16,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cfd_mac.sv]
module cfd_mac import cfd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic signed [SAMPLE_W-1:0] smp_i_i,
  input  logic signed [SAMPLE_W-1:0] smp_q_i,
  output logic                       done_o,
  output res_t                       res_o
);

  localparam int RW = ACC_W - COEF_W + 2;
  localparam logic signed [RW-1:0] SMAX = RW'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [RW-1:0] SMIN = ~SMAX;

  mac_ctrl_t                ctrl_q;
  logic signed [PROD_W-1:0] prod_i_q, prod_q_q;
  logic signed [ACC_W-1:0]  acc_i_q, acc_q_q;
  logic signed [ACC_W-1:0]  base_i, base_q;
  logic                     done_q;

  // rounded value in the low bits, clip flag on top
  function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [RW-1:0] v;
    logic                 clip;
    logic [SAMPLE_W-1:0]  r;
    v = $signed({acc[ACC_W-1], acc[ACC_W-1:COEF_W-1]})
        + $signed({{(RW-1){1'b0}}, acc[COEF_W-2]});
    clip = 1'b0;
    r = v[SAMPLE_W-1:0];
    if (v > SMAX) begin
      clip = 1'b1;
      r = SMAX[SAMPLE_W-1:0];
    end else if (v < SMIN) begin
      clip = 1'b1;
      r = SMIN[SAMPLE_W-1:0];
    end
    return {clip, r};
  endfunction

  assign base_i = ctrl_q.first ? '0 : acc_i_q;
  assign base_q = ctrl_q.first ? '0 : acc_q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctrl_q <= ctrl_i;
      done_q <= ctrl_q.vld && ctrl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_i_q <= coef_i * smp_i_i;
    prod_q_q <= coef_i * smp_q_i;
    if (ctrl_q.vld) begin
      acc_i_q <= base_i + ACC_W'(prod_i_q);
      acc_q_q <= base_q + ACC_W'(prod_q_q);
    end
  end

  logic [SAMPLE_W:0] fin_i, fin_q;

  assign fin_i = round_sat(acc_i_q);
  assign fin_q = round_sat(acc_q_q);

  assign res_o.out_i     = fin_i[SAMPLE_W-1:0];
  assign res_o.out_q     = fin_q[SAMPLE_W-1:0];
  assign res_o.saturated = fin_i[SAMPLE_W] | fin_q[SAMPLE_W];
  assign done_o          = done_q;

endmodule

[hdl/complex_fir_decimator.sv]
// channel  | dir | payload                                           | moves on
// ---------+-----+---------------------------------------------------+-------------------
// req      | in  | req_type, sample_i, sample_q, tap_index, tap_value | valid && ready
// res      | out | out_i, out_q, saturated                           | valid && ready
// cfg      | in  | cfg_idx_i, cfg_wdata_i                            | cfg_we_i
//
// a coefficient write or a sample that does not complete a phase is stored from idle
// a sample that completes a phase runs over the active taps, one tap a cycle
// through the shared complex multiply-accumulate reading both memories
// after reset a clearing pass over all 256 entries zeroes both memories, no request taken
// the output register holds a result under stall while the next request is taken
`include "complex_fir_decimator_defines.svh"

module complex_fir_decimator import cfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  cfd_req_if.sink           req,
  cfd_res_if.source         res
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [TAP_AW-1:0] clr_q;
  logic [CFG_W-1:0]  decim_q, ntaps_q;
  logic [TAP_AW-1:0] wp_q;
  logic [PHASE_W-1:0] phase_q;
  logic [TAP_AW:0]   n_q, k_q;
  logic [TAP_AW-1:0] rd_q;
  mac_ctrl_t         ctrl_q, ctrl_d;
  logic              out_vld_q;
  res_t              out_q;

  logic [CFG_W-1:0]  n_eff, m_eff;
  logic [TAP_AW-1:0] wp_eff, wp_nxt;
  logic [TAP_AW:0]   wp_inc;
  logic [PHASE_W:0]  ph_inc;
  logic              emit, accept, is_coef, clearing;
  logic              last_tap, load_out;
  logic              dl_we, cf_we;
  logic [TAP_AW-1:0] dl_waddr, cf_waddr;
  logic [2*SAMPLE_W-1:0] dl_wdata, dl_rdata;
  logic [COEF_W-1:0] cf_wdata, cf_rdata;
  logic              mac_done;
  res_t              mac_res;

  always_comb begin
    n_eff = ntaps_q;
    if (ntaps_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (ntaps_q > CFG_W'(MAX_TAPS)) begin
      n_eff = CFG_W'(MAX_TAPS);
    end
    m_eff = decim_q;
    if (decim_q == '0) begin
      m_eff = CFG_W'(1);
    end else if (decim_q > CFG_W'(MAX_DECIM)) begin
      m_eff = CFG_W'(MAX_DECIM);
    end
  end

  assign clearing = (state_q == ST_CLEAR);
  assign req.ready = (state_q == ST_IDLE);
  assign accept = req.valid && req.ready;
  assign is_coef = (req.data.req_type == REQ_COEF);

  assign wp_eff = ({1'b0, wp_q} >= n_eff) ? '0 : wp_q;
  assign wp_inc = {1'b0, wp_eff} + (TAP_AW+1)'(1);
  assign wp_nxt = (wp_inc >= n_eff) ? '0 : wp_inc[TAP_AW-1:0];
  assign ph_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);
  assign emit = (ph_inc >= m_eff);

  assign last_tap = (k_q == n_q - (TAP_AW+1)'(1));
  assign load_out = (state_q == ST_FIN) && (!out_vld_q || res.ready);

  always_comb begin
    ctrl_d = '0;
    if (state_q == ST_MAC) begin
      ctrl_d.vld   = 1'b1;
      ctrl_d.first = (k_q == '0);
      ctrl_d.last  = last_tap;
    end
  end

  assign dl_we    = clearing || (accept && !is_coef);
  assign dl_waddr = clearing ? clr_q : wp_eff;
  assign dl_wdata = clearing ? '0 : {req.data.sample_i, req.data.sample_q};
  assign cf_we    = clearing || (accept && is_coef);
  assign cf_waddr = clearing ? clr_q : req.data.tap_index;
  assign cf_wdata = clearing ? '0 : req.data.tap_value;

  cfd_ram #(.Depth(MAX_TAPS), .Width(2*SAMPLE_W)) u_dline (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (rd_q),
    .rdata_o (dl_rdata)
  );

  cfd_ram #(.Depth(MAX_TAPS), .Width(COEF_W)) u_coef (
    .clk_i   (clk_i),
    .we_i    (cf_we),
    .waddr_i (cf_waddr),
    .wdata_i (cf_wdata),
    .raddr_i (k_q[TAP_AW-1:0]),
    .rdata_o (cf_rdata)
  );

  cfd_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_q),
    .coef_i  ($signed(cf_rdata)),
    .smp_i_i ($signed(dl_rdata[2*SAMPLE_W-1:SAMPLE_W])),
    .smp_q_i ($signed(dl_rdata[SAMPLE_W-1:0])),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      decim_q   <= CFG_W'(1);
      ntaps_q   <= CFG_W'(9);
      wp_q      <= '0;
      phase_q   <= '0;
      n_q       <= '0;
      k_q       <= '0;
      rd_q      <= '0;
      ctrl_q    <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DECIM: decim_q <= cfg_wdata_i;
          CFG_TAPS:  ntaps_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (load_out) begin
        out_q     <= mac_res;
        out_vld_q <= 1'b1;
      end else if (res.ready) begin
        out_vld_q <= 1'b0;
      end
      ctrl_q <= ctrl_d;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + TAP_AW'(1);
          if (clr_q == TAP_AW'(MAX_TAPS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && !is_coef) begin
            wp_q <= wp_nxt;
            if (emit) begin
              phase_q <= '0;
              n_q     <= n_eff;
              k_q     <= '0;
              rd_q    <= wp_eff;
              state_q <= ST_MAC;
            end else begin
              phase_q <= ph_inc[PHASE_W-1:0];
            end
          end
        end
        ST_MAC: begin
          k_q  <= k_q + (TAP_AW+1)'(1);
          rd_q <= (rd_q == '0) ? (n_q[TAP_AW-1:0] - TAP_AW'(1)) : (rd_q - TAP_AW'(1));
          if (last_tap) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res.valid = out_vld_q;
  assign res.data  = out_q;

  `CFD_ASSERT_IMPL(a_done_in_drain, mac_done, state_q == ST_DRAIN, "mac finished outside drain")
  `CFD_ASSERT_IMPL(a_read_in_ring, state_q == ST_MAC, rd_q < n_q && k_q < n_q, "read beyond ring")
  `CFD_ASSERT_IMPL(a_out_from_fin, $rose(out_vld_q), $past(state_q) == ST_FIN, "stray result")
  `CFD_ASSERT_IMPL(a_no_take_busy, ctrl_q.vld, !accept, "request taken during accumulation")

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cfd_pkg::*;

  localparam int CLK_PERIOD         = 2;
  localparam int RESET_CYCLES       = 10;
  localparam int SETTLE_CYCLES      = MAX_TAPS + 8;
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int LONG_HOLD          = 400;
  localparam int RANDOM_ITEMS       = 640;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  cfd_req_if req_ch ();
  cfd_res_if res_ch ();

  complex_fir_decimator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .res         (res_ch)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // filter state mirrored on the testbench side
  logic signed [SAMPLE_W-1:0] ring_i   [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] ring_q   [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  int                         ring_pos;
  int                         phase_cnt;
  logic [CFG_W-1:0]           decim_cfg;
  logic [CFG_W-1:0]           taps_cfg;

  req_t pending_reqs[$];
  res_t expected_outputs[$];

  int  items_queued;
  int  n_errors;
  int  quiet_cycles;
  int  src_gap;
  int  sink_gap;
  int  hold_left;
  bit  idle_on;
  bit  long_hold_arm;

  function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc, inout logic clip);
    longint wide;
    longint v;
    longint maxv;
    wide = acc;
    maxv = (longint'(1) << (SAMPLE_W - 1)) - 1;
    v = (wide >>> (COEF_W - 1)) + ((wide >>> (COEF_W - 2)) & 1);
    if (v > maxv) begin
      clip = 1'b1;
      v = maxv;
    end else if (v < -maxv - 1) begin
      clip = 1'b1;
      v = -maxv - 1;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic void filter_and_decimate(input req_t r);
    int                      n;
    int                      m;
    int                      idx;
    int                      k;
    logic signed [ACC_W-1:0] acc_i;
    logic signed [ACC_W-1:0] acc_q;
    logic                    clip;
    res_t                    res_exp;
    if (r.req_type == REQ_COEF) begin
      coef_mem[r.tap_index] = r.tap_value;
      return;
    end
    n = (taps_cfg == 0) ? 1 : (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
    m = (decim_cfg == 0) ? 1 : (decim_cfg > MAX_DECIM) ? MAX_DECIM : int'(decim_cfg);
    if (ring_pos >= n) ring_pos = 0;
    ring_i[ring_pos] = r.sample_i;
    ring_q[ring_pos] = r.sample_q;
    idx = ring_pos;
    ring_pos = (ring_pos + 1 >= n) ? 0 : ring_pos + 1;
    phase_cnt++;
    if (phase_cnt < m) begin
      phase_cnt &= 8'hFF;
      return;
    end
    phase_cnt = 0;
    acc_i = '0;
    acc_q = '0;
    for (k = 0; k < n; k++) begin
      acc_i = acc_i + coef_mem[k] * ring_i[idx];
      acc_q = acc_q + coef_mem[k] * ring_q[idx];
      idx = (idx == 0) ? n - 1 : idx - 1;
    end
    clip = 1'b0;
    res_exp.out_i = round_sat(acc_i, clip);
    res_exp.out_q = round_sat(acc_q, clip);
    res_exp.saturated = clip;
    expected_outputs.insert(expected_outputs.size(), res_exp);
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    n_errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_decim();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CFG_W'(MAX_DECIM);
      2: return '1;
      3: return CFG_W'($urandom);
      4, 5: return CFG_W'(1);
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_taps();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(2);
      3: return CFG_W'(MAX_TAPS);
      4: return '1;
      default: return CFG_W'($urandom_range(3, 24));
    endcase
  endfunction

  task automatic push_sample(input logic [15:0] si, input logic [15:0] sq);
    req_t r;
    r.req_type  = REQ_SAMPLE;
    r.sample_i  = si;
    r.sample_q  = sq;
    r.tap_index = TAP_AW'($urandom);
    r.tap_value = COEF_W'($urandom);
    pending_reqs.insert(pending_reqs.size(), r);
    items_queued++;
  endtask

  task automatic push_coef(input logic [TAP_AW-1:0] idx, input logic [15:0] val);
    req_t r;
    r.req_type  = REQ_COEF;
    r.sample_i  = SAMPLE_W'($urandom);
    r.sample_q  = SAMPLE_W'($urandom);
    r.tap_index = idx;
    r.tap_value = val;
    pending_reqs.insert(pending_reqs.size(), r);
    items_queued++;
  endtask

  task automatic push_rand_sample();
    push_sample(rand_word(), rand_word());
  endtask

  task automatic push_rand_coef(input int n_eff, input bit small_coefs);
    logic [TAP_AW-1:0] idx;
    logic [15:0]       val;
    idx = ($urandom_range(0, 7) == 0) ? TAP_AW'($urandom)
                                      : TAP_AW'($urandom_range(0, n_eff - 1));
    val = small_coefs ? 16'($urandom_range(0, 4095) - 2048) : rand_word();
    push_coef(idx, val);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DECIM) begin
      decim_cfg = val;
    end else begin
      taps_cfg = val;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_until_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_phase();
    int n_eff;
    int n_items;
    bit small_coefs;
    idle_on = ($urandom_range(0, 4) != 0);
    small_coefs = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_DECIM, pick_decim());
    if ($urandom_range(0, 3) != 0) write_reg(CFG_TAPS, pick_taps());
    n_eff = (taps_cfg == 0) ? 1 : (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
    n_items = (n_eff > 64) ? $urandom_range(4, 12) : $urandom_range(20, 80);
    repeat ($urandom_range(0, 6)) push_rand_coef(n_eff, small_coefs);
    repeat (n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        push_rand_coef(n_eff, small_coefs);
      end else begin
        push_rand_sample();
      end
    end
    wait_until_idle();
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      src_gap      <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (src_gap != 0) begin
        req_ch.valid <= 1'b0;
        src_gap      <= src_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        req_ch.valid <= 1'b0;
        src_gap      <= $urandom_range(0, 9);
      end else if (pending_reqs.size() != 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_reqs.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      sink_gap     <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (long_hold_arm) begin
      res_ch.ready  <= 1'b0;
      hold_left     <= LONG_HOLD - 1;
      long_hold_arm <= 1'b0;
    end else if (sink_gap != 0) begin
      res_ch.ready <= 1'b0;
      sink_gap     <= sink_gap - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      sink_gap     <= $urandom_range(0, 9);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      filter_and_decimate(req_ch.data);
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_outputs.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected, expected none, actual %0d %0d %0d",
                 $time, res_ch.data.out_i, res_ch.data.out_q, res_ch.data.saturated);
      end else begin
        want = expected_outputs.pop_front();
        if (res_ch.data.out_i !== want.out_i) note_mismatch("out_i", want.out_i, res_ch.data.out_i);
        if (res_ch.data.out_q !== want.out_q) note_mismatch("out_q", want.out_q, res_ch.data.out_q);
        if (res_ch.data.saturated !== want.saturated) begin
          note_mismatch("saturated", want.saturated, res_ch.data.saturated);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int start_items;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DECIM;
    cfg_wdata_i   = '0;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    res_ch.ready  = 1'b0;
    idle_on       = 1'b1;
    long_hold_arm = 1'b0;
    foreach (ring_i[k]) begin
      ring_i[k]   = '0;
      ring_q[k]   = '0;
      coef_mem[k] = '0;
    end
    ring_pos  = 0;
    phase_cnt = 0;
    decim_cfg = CFG_W'(1);
    taps_cfg  = CFG_W'(9);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // rounding ties go toward plus infinity, then full-scale coefficients and samples
    push_coef(0, 16'h0001);
    push_sample(16'h4000, 16'hC000);
    push_coef(0, 16'h7FFF);
    push_coef(1, 16'h8000);
    push_coef(2, 16'h0001);
    push_coef(8, 16'hFFFF);
    push_coef(255, 16'h8000);
    push_sample(16'h7FFF, 16'h8000);
    push_sample(16'h8000, 16'h7FFF);
    push_sample(16'h8000, 16'h8000);
    push_sample(16'h0000, 16'h0000);
    push_sample(16'hFFFF, 16'h0001);
    push_sample(16'h7FFF, 16'h7FFF);
    push_sample(16'h0001, 16'hFFFF);
    wait_until_idle();

    // zero length and zero factor, then short rings
    write_reg(CFG_TAPS, '0);
    write_reg(CFG_DECIM, '0);
    repeat (3) push_rand_sample();
    wait_until_idle();
    write_reg(CFG_TAPS, CFG_W'(1));
    repeat (2) push_rand_sample();
    wait_until_idle();
    write_reg(CFG_TAPS, CFG_W'(2));
    write_reg(CFG_DECIM, CFG_W'(2));
    repeat (3) push_rand_sample();
    wait_until_idle();

    // phase left beyond a smaller factor
    write_reg(CFG_TAPS, CFG_W'(9));
    write_reg(CFG_DECIM, CFG_W'(8));
    repeat (5) push_rand_sample();
    wait_until_idle();
    write_reg(CFG_DECIM, CFG_W'(2));
    push_rand_sample();
    wait_until_idle();

    // oversized settings clamp to the longest ring and slowest rate
    write_reg(CFG_TAPS, '1);
    write_reg(CFG_DECIM, '1);
    repeat (258) push_rand_sample();
    wait_until_idle();

    // receiver holds off while requests keep coming
    write_reg(CFG_TAPS, CFG_W'(3));
    write_reg(CFG_DECIM, CFG_W'(1));
    long_hold_arm = 1'b1;
    repeat (60) push_rand_sample();
    wait_until_idle();

    start_items = items_queued;
    while (items_queued - start_items < RANDOM_ITEMS) begin
      random_phase();
    end

    idle_on = 1'b0;
    write_reg(CFG_DECIM, CFG_W'(2));
    write_reg(CFG_TAPS, CFG_W'(8));
    repeat (100) push_rand_sample();
    wait_until_idle();

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
